[rtl/assert_macros.svh]
// Assertion macros shared by the odometry RTL.
// Include by bare file name; each macro emits one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`endif

[rtl/ddo_pkg.sv]
// Shared types and constants for the differential-drive odometry block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ddo_pkg;
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_SETH  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
    localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
        logic [15:0]        elapsed;
        logic signed [15:0] new_heading;
    } t_item;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] v;
        begin
            unique case (i)
                5'd0: v = 32'h20000000;   5'd1: v = 32'h12E4051E;
                5'd2: v = 32'h09FB385B;   5'd3: v = 32'h051111D4;
                5'd4: v = 32'h028B0D43;   5'd5: v = 32'h0145D7E1;
                5'd6: v = 32'h00A2F61E;   5'd7: v = 32'h00517C55;
                5'd8: v = 32'h0028BE53;   5'd9: v = 32'h00145F2F;
                5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
                5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
                5'd14: v = 32'h0000A2FA;  5'd15: v = 32'h0000517D;
                5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
                5'd18: v = 32'h00000A30;  5'd19: v = 32'h00000518;
                5'd20: v = 32'h0000028C;  5'd21: v = 32'h00000146;
                5'd22: v = 32'h000000A3;  5'd23: v = 32'h00000051;
                default: v = 32'h0;
            endcase
            return v;
        end
    endfunction
endpackage
`default_nettype wire

[rtl/ddo_front.sv]
// Input stage and two-entry item queue of the odometry block.
// Depends on ddo_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ddo_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire ddo_pkg::t_item i_item,
    output logic                o_q_valid,
    input  wire logic           i_q_pop,
    output ddo_pkg::t_item      o_q_item
);
    import ddo_pkg::*;

    t_item      r_mem [2];
    logic       r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       push;

    assign o_stall   = (r_cnt == 2'd2);
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];

    always_comb begin
        n_wp  = push ? ~r_wp : r_wp;
        n_rp  = i_q_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, push} - {1'b0, i_q_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
    end
endmodule
`default_nettype wire

[rtl/ddo_back.sv]
// Sequential execution unit: rate, heading, CORDIC and position update.
// Depends on ddo_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ddo_back #(
    parameter int ANGLE_BITS      = 16,
    parameter int TRIG_ITERATIONS = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [15:0]    i_inv_wheel_base,
    input  wire logic           i_q_valid,
    output logic                o_q_pop,
    input  wire ddo_pkg::t_item i_q_item,
    output logic                o_valid,
    input  wire logic           i_stall,
    output logic signed [31:0]  o_pos_x,
    output logic signed [31:0]  o_pos_y,
    output logic signed [15:0]  o_heading,
    output logic signed [15:0]  o_speed,
    output logic signed [15:0]  o_turn_rate
);
    import ddo_pkg::*;

    localparam int AB = ANGLE_BITS;
    localparam int DSH = 58 - AB;
    localparam int UP = (AB >= 16) ? AB - 16 : 0;
    localparam int DN = (AB < 16) ? 16 - AB : 0;
    localparam int ITW = $clog2(TRIG_ITERATIONS + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RATE = 4'd1;
    localparam logic [3:0] S_D1   = 4'd2;
    localparam logic [3:0] S_D2   = 4'd3;
    localparam logic [3:0] S_MID  = 4'd4;
    localparam logic [3:0] S_COR  = 4'd5;
    localparam logic [3:0] S_M1   = 4'd6;
    localparam logic [3:0] S_M2   = 4'd7;
    localparam logic [3:0] S_ACC  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0]           r_st;
    logic [ITW-1:0]       r_it;
    t_item                r_item;
    logic [31:0]          r_x, r_y;
    logic [AB-1:0]        r_ang, r_prev;
    logic signed [15:0]   r_spd, r_rate;
    logic signed [47:0]   r_p1;
    logic signed [63:0]   r_p2;
    logic signed [33:0]   r_cx, r_cy, r_cz;
    logic                 r_flip;
    logic signed [63:0]   r_mx, r_my;
    logic                 r_out_v;
    logic signed [31:0]   r_ox, r_oy;
    logic signed [15:0]   r_oh, r_os, r_or;

    logic signed [17:0]   l_sum, diff;
    logic signed [34:0]   wprod;
    logic signed [34:0]   wr;
    logic [AB-1:0]        new_ang, dang, mid;
    logic signed [AB-1:0] dsig;
    logic signed [31:0]   z32;
    logic signed [33:0]   zf, xs, ys, atn;
    logic                 fl;
    logic signed [63:0]   rnd;

    assign o_q_pop = (r_st == S_IDLE) && i_q_valid;

    always_comb begin
        l_sum   = 18'(r_item.left_speed) + 18'(r_item.right_speed) + 18'sd1;
        diff    = 18'(r_item.right_speed) - 18'(r_item.left_speed);
        wprod   = 35'(diff) * $signed({19'd0, i_inv_wheel_base});
        wr      = (wprod + 35'sd512) >>> 10;
        new_ang = r_prev + AB'(r_p2 >>> DSH);
        dang    = new_ang - r_prev;
        dsig    = $signed(dang);
        mid     = r_prev + AB'(dsig >>> 1);
        z32     = $signed({mid, {(32 - AB){1'b0}}});
        fl      = (z32 > 32'sh40000000) || (z32 < -32'sh40000000);
        zf      = fl ? ((z32 > 0) ? 34'(z32) - 34'sh80000000
                                   : 34'(z32) + 34'sh80000000) : 34'(z32);
        xs      = r_cx >>> r_it;
        ys      = r_cy >>> r_it;
        atn     = 34'($signed(atan_entry(5'(r_it))));
        rnd     = 64'sd1 <<< 41;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_out_v <= 1'b0;
            r_x     <= '0;
            r_y     <= '0;
            r_ang   <= '0;
            r_spd   <= '0;
            r_rate  <= '0;
        end else begin
            if (r_out_v && !i_stall && (r_st != S_OUT)) begin
                r_out_v <= 1'b0;
            end
            unique case (r_st)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_item <= i_q_item;
                        unique case (i_q_item.op)
                            OP_TICK: r_st <= (i_q_item.elapsed == 16'd0) ? S_OUT : S_RATE;
                            OP_SETH: begin
                                r_ang <= AB'((32'($unsigned(i_q_item.new_heading)) << UP) >> DN);
                                r_st  <= S_OUT;
                            end
                            OP_CLEAR: begin
                                r_x <= '0; r_y <= '0; r_ang <= '0;
                                r_spd <= '0; r_rate <= '0;
                                r_st <= S_OUT;
                            end
                            default: r_st <= S_OUT;
                        endcase
                    end
                end
                S_RATE: begin
                    r_spd  <= 16'(l_sum >>> 1);
                    r_rate <= (wr > 35'sd32767) ? 16'sh7FFF :
                              (wr < -35'sd32768) ? 16'sh8000 : 16'(wr);
                    r_prev <= r_ang;
                    r_st   <= S_D1;
                end
                S_D1: begin
                    r_p1 <= 48'(r_rate) * $signed({1'b0, r_item.elapsed});
                    r_st <= S_D2;
                end
                S_D2: begin
                    r_p2 <= 64'(r_p1) * $signed({34'd0, INV_TWO_PI_Q32})
                            + (64'sd1 <<< (DSH - 1));
                    r_st <= S_MID;
                end
                S_MID: begin
                    r_ang  <= new_ang;
                    r_cx   <= 34'(CORDIC_GAIN_Q30);
                    r_cy   <= '0;
                    r_cz   <= zf;
                    r_flip <= fl;
                    r_st   <= S_COR;
                    r_it   <= '0;
                end
                S_COR: begin
                    r_st <= S_COR;
                    if (r_it == ITW'(TRIG_ITERATIONS)) begin
                        r_st <= S_M1;
                    end else begin
                        r_it <= r_it + ITW'(1);
                        if (r_cz >= 0) begin
                            r_cx <= r_cx - ys;
                            r_cy <= r_cy + xs;
                            r_cz <= r_cz - atn;
                        end else begin
                            r_cx <= r_cx + ys;
                            r_cy <= r_cy - xs;
                            r_cz <= r_cz + atn;
                        end
                    end
                end
                S_M1: begin
                    r_mx <= 64'(r_spd) * 64'(r_flip ? -r_cx : r_cx);
                    r_my <= 64'(r_spd) * 64'(r_flip ? -r_cy : r_cy);
                    r_st <= S_M2;
                end
                S_M2: begin
                    r_mx <= r_mx * $signed({48'd0, r_item.elapsed}) + rnd;
                    r_my <= r_my * $signed({48'd0, r_item.elapsed}) + rnd;
                    r_st <= S_ACC;
                end
                S_ACC: begin
                    r_x  <= r_x + 32'(r_mx >>> 42);
                    r_y  <= r_y + 32'(r_my >>> 42);
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_v || !i_stall) begin
                        r_out_v <= 1'b1;
                        r_ox <= r_x;
                        r_oy <= r_y;
                        r_oh <= 16'((32'(r_ang) >> UP) << DN);
                        r_os <= r_spd;
                        r_or <= r_rate;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_valid     = r_out_v;
    assign o_pos_x     = r_ox;
    assign o_pos_y     = r_oy;
    assign o_heading   = r_oh;
    assign o_speed     = r_os;
    assign o_turn_rate = r_or;
endmodule
`default_nettype wire

[rtl/differential_drive_odometry_top.sv]
// Top level of the differential-drive odometry block.
// Depends on ddo_pkg, ddo_front, ddo_back and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
// A tick passes the execution unit through its states in order (rate, two heading
// multiplies, midpoint, one CORDIC step per cycle and a closing check, two position
// multiplies, accumulate, output); set-heading, clear, no-op and zero-time ticks go
// straight to output. A two-entry queue takes items while the unit works.
`include "assert_macros.svh"
module differential_drive_odometry_top #(
    parameter int ANGLE_BITS      = 16,
    parameter int TRIG_ITERATIONS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_opcode,
    input  wire logic signed [15:0] i_left_speed,
    input  wire logic signed [15:0] i_right_speed,
    input  wire logic [15:0]        i_elapsed,
    input  wire logic signed [15:0] i_new_heading,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_pos_x,
    output logic signed [31:0]      o_pos_y,
    output logic signed [15:0]      o_heading,
    output logic signed [15:0]      o_speed,
    output logic signed [15:0]      o_turn_rate
);
    import ddo_pkg::*;

    logic [15:0] r_iwb;
    t_item       in_item, q_item;
    logic        q_valid, q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iwb <= 16'd640;
        end else if (i_cfg_we) begin
            r_iwb <= i_cfg_data;
        end
    end

    assign in_item = '{op: i_opcode, left_speed: i_left_speed,
                       right_speed: i_right_speed, elapsed: i_elapsed,
                       new_heading: i_new_heading};

    ddo_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_item(in_item),
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_item(q_item)
    );

    ddo_back #(.ANGLE_BITS(ANGLE_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_back (
        .i_clk, .i_rst_n, .i_inv_wheel_base(r_iwb),
        .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_item(q_item),
        .o_valid, .i_stall, .o_pos_x, .o_pos_y, .o_heading, .o_speed, .o_turn_rate
    );

    `ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, q_pop && !q_valid)
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n,
        (o_valid && i_stall) |=> (o_valid && $stable(o_pos_x) && $stable(o_heading)))
    `ASSERT_CLK(a_cfg_take, i_clk, i_rst_n, i_cfg_we |=> (r_iwb == $past(i_cfg_data)))
endmodule
`default_nettype wire

[tb/differential_drive_odometry_top_tb.sv]
// Self-checking testbench for differential_drive_odometry_top: drives ticks,
// heading sets, clears and no-ops, predicts each pose result, and checks it.
// Depends on ddo_pkg and the RTL of the block.
`timescale 1ns / 1ps
module differential_drive_odometry_top_tb;
    import ddo_pkg::*;

    localparam longint CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [15:0] heading;
        logic [15:0] speed;
        logic [15:0] turn_rate;
    } t_pose;

    class odo_scoreboard;
        logic [31:0] x_pos, y_pos;
        logic [15:0] angle, spd, rate;
        logic [15:0] inv_base;
        t_pose poses_due[$];
        int mismatches;
        int checked;
        longint atan_q32[16] = '{
            'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
            'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
            'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D};

        function new();
            x_pos = 0; y_pos = 0; angle = 0; spd = 0; rate = 0;
            inv_base = 16'd640;
            mismatches = 0;
            checked = 0;
        endfunction

        static function longint heading_step(longint w, longint dt);
            return (w * dt * 64'sd683565276 + (64'sd1 <<< 41)) >>> 42;
        endfunction

        function void sin_cos(logic [15:0] mid, output longint c, output longint s);
            longint z, xc, yc, t;
            bit flip;
            z = longint'($signed({mid, 16'h0000}));
            xc = 64'sd652032874;
            yc = 0;
            flip = 0;
            if (z > (64'sd1 <<< 30)) begin
                z -= 64'sd1 <<< 31;
                flip = 1;
            end else if (z < -(64'sd1 <<< 30)) begin
                z += 64'sd1 <<< 31;
                flip = 1;
            end
            for (int i = 0; i < 16; i++) begin
                if (z >= 0) begin
                    t = xc - (yc >>> i);
                    yc = yc + (xc >>> i);
                    z -= atan_q32[i];
                end else begin
                    t = xc + (yc >>> i);
                    yc = yc - (xc >>> i);
                    z += atan_q32[i];
                end
                xc = t;
            end
            c = flip ? -xc : xc;
            s = flip ? -yc : yc;
        endfunction

        function void note_item(logic [1:0] op, logic [15:0] ls, logic [15:0] rs,
                                logic [15:0] el, logic [15:0] nh);
            longint l, r, dt, w, dlt, c, s, sv;
            logic [15:0] prev, d, mid;
            t_pose p;
            l = longint'($signed(ls));
            r = longint'($signed(rs));
            dt = longint'(el);
            case (op)
                OP_TICK: begin
                    if (dt != 0) begin
                        spd = 16'((l + r + 1) >>> 1);
                        w = ((r - l) * longint'(inv_base) + 512) >>> 10;
                        if (w > 32767) w = 32767;
                        if (w < -32768) w = -32768;
                        rate = 16'(w);
                        prev = angle;
                        dlt = heading_step(w, dt);
                        angle = prev + 16'(dlt);
                        d = angle - prev;
                        mid = prev + 16'($signed(d) >>> 1);
                        sin_cos(mid, c, s);
                        sv = longint'($signed(spd));
                        x_pos += 32'((sv * c * dt + (64'sd1 <<< 41)) >>> 42);
                        y_pos += 32'((sv * s * dt + (64'sd1 <<< 41)) >>> 42);
                    end
                end
                OP_SETH: angle = nh;
                OP_CLEAR: begin
                    x_pos = 0; y_pos = 0; angle = 0; spd = 0; rate = 0;
                end
                default: ;
            endcase
            p.pos_x = x_pos; p.pos_y = y_pos; p.heading = angle;
            p.speed = spd; p.turn_rate = rate;
            poses_due.push_back(p);
        endfunction

        function void check_result(t_pose got);
            t_pose exp_p;
            checked++;
            if (poses_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result x=%h y=%h h=%h", got.pos_x, got.pos_y,
                             got.heading);
                return;
            end
            exp_p = poses_due.pop_front();
            if (got.pos_x !== exp_p.pos_x || got.pos_y !== exp_p.pos_y ||
                got.heading !== exp_p.heading || got.speed !== exp_p.speed ||
                got.turn_rate !== exp_p.turn_rate) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: #%0d exp %h %h %h %h %h got %h %h %h %h %h",
                             checked, exp_p.pos_x, exp_p.pos_y, exp_p.heading, exp_p.speed,
                             exp_p.turn_rate, got.pos_x, got.pos_y, got.heading, got.speed,
                             got.turn_rate);
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [15:0] i_cfg_data = 0;
    logic i_valid = 0;
    logic [1:0] i_opcode = OP_NOP;
    logic signed [15:0] i_left_speed = 0;
    logic signed [15:0] i_right_speed = 0;
    logic [15:0] i_elapsed = 0;
    logic signed [15:0] i_new_heading = 0;
    logic i_stall = 0;
    logic o_stall, o_valid;
    logic signed [31:0] o_pos_x, o_pos_y;
    logic signed [15:0] o_heading, o_speed, o_turn_rate;

    odo_scoreboard sb = new();
    longint cycles = 0;
    int items_sent = 0;
    int burst_left = 0;
    int hold_cnt = 0;
    int stall_mode = 0;

    differential_drive_odometry_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_opcode(i_opcode), .i_left_speed(i_left_speed), .i_right_speed(i_right_speed),
        .i_elapsed(i_elapsed), .i_new_heading(i_new_heading),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_pos_x(o_pos_x), .o_pos_y(o_pos_y), .o_heading(o_heading),
        .o_speed(o_speed), .o_turn_rate(o_turn_rate)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("differential_drive_odometry_top_tb NOT OK");
            $finish;
        end
    end

    // receiver: phased stall pattern, plus long hold-offs
    always @(posedge i_clk) begin
        if (cycles % 300 == 0)
            stall_mode <= $urandom_range(0, 2);
        if (cycles == 3000 || cycles == 40000)
            hold_cnt <= 600;
        else if (hold_cnt > 0)
            hold_cnt <= hold_cnt - 1;
        if (hold_cnt > 0) begin
            i_stall <= 1'b1;
        end else begin
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                default: i_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            sb.note_item(i_opcode, i_left_speed, i_right_speed, i_elapsed, i_new_heading);
            items_sent++;
        end
    end

    always @(posedge i_clk) begin
        t_pose got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.pos_x = o_pos_x; got.pos_y = o_pos_y; got.heading = o_heading;
            got.speed = o_speed; got.turn_rate = o_turn_rate;
            sb.check_result(got);
        end
    end

    task automatic push_item(t_item it);
        int gap;
        i_valid <= 1'b1;
        i_opcode <= it.op;
        i_left_speed <= it.left_speed;
        i_right_speed <= it.right_speed;
        i_elapsed <= it.elapsed;
        i_new_heading <= it.new_heading;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.poses_due.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_inv_base(logic [15:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        sb.inv_base = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_item mk(logic [1:0] op, int l, int r, int dt, int h);
        t_item it;
        it.op = op;
        it.left_speed = 16'(l);
        it.right_speed = 16'(r);
        it.elapsed = 16'(dt);
        it.new_heading = 16'(h);
        return it;
    endfunction

    function automatic t_item random_item();
        int k;
        t_item it;
        k = $urandom_range(0, 99);
        it = mk(OP_NOP, $urandom, $urandom, $urandom, $urandom);
        if (k < 80) begin
            it.op = OP_TICK;
            if ($urandom_range(0, 1)) begin
                it.left_speed = 16'($urandom_range(0, 8000) - 4000);
                it.right_speed = 16'(int'(it.left_speed) + $urandom_range(0, 800) - 400);
            end
            case ($urandom_range(0, 19))
                0: it.elapsed = 0;
                1, 2: it.elapsed = 16'($urandom);
                default: it.elapsed = 16'($urandom_range(1, 2000));
            endcase
        end else if (k < 88) begin
            it.op = OP_SETH;
        end else if (k < 93) begin
            it.op = OP_CLEAR;
        end
        return it;
    endfunction

    initial begin
        logic [15:0] inv_list[7];
        int pi_dt;
        int phase_items;
        inv_list = '{16'd1, 16'd65535, 16'($urandom_range(1, 65535)),
                     16'($urandom_range(200, 2000)), 16'($urandom_range(1, 65535)), 16'd640,
                     16'd640};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_inv_base(16'd640);

        // find a step whose heading change is exactly a half turn
        pi_dt = 1;
        for (int dt = 1; dt < 65536; dt++)
            if (16'(odo_scoreboard::heading_step(32767, dt)) == 16'h8000) begin
                pi_dt = dt;
                break;
            end

        push_item(mk(OP_TICK, 32767, 32767, 65535, 0));
        push_item(mk(OP_TICK, -32768, -32768, 65535, 0));
        push_item(mk(OP_TICK, -32768, 32767, 1, 0));
        push_item(mk(OP_TICK, 32767, -32768, 65535, 0));
        push_item(mk(OP_TICK, 1234, -4321, 0, 0));
        push_item(mk(OP_SETH, 0, 0, 0, 32767));
        push_item(mk(OP_TICK, 4096, 4096, 3000, 0));
        push_item(mk(OP_SETH, 0, 0, 0, -32768));
        push_item(mk(OP_TICK, 4096, 4096, 3000, 0));
        push_item(mk(OP_SETH, 0, 0, 0, 16384));
        push_item(mk(OP_TICK, -32768, 32767, pi_dt, 0));
        push_item(mk(OP_SETH, 0, 0, 0, -16384));
        push_item(mk(OP_TICK, 2000, 2100, 700, 0));
        push_item(mk(OP_NOP, -1, -1, 65535, -1));
        push_item(mk(OP_CLEAR, 5, 5, 5, 5));
        push_item(mk(OP_TICK, 0, 0, 100, 0));
        push_item(mk(OP_TICK, 32767, 32767, 65535, 0));
        push_item(mk(OP_TICK, 32767, 32767, 65535, 0));
        drain();

        foreach (inv_list[p]) begin
            write_inv_base(inv_list[p]);
            phase_items = 250;
            for (int n = 0; n < phase_items; n++)
                push_item(random_item());
            drain();
        end

        $display("Covered %0d items, %0d results checked, over %0d wheel-base settings.",
                 items_sent, sb.checked, 8);
        if (sb.mismatches == 0 && sb.poses_due.size() == 0) begin
            $display("differential_drive_odometry_top_tb OK");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches,
                     sb.poses_due.size());
            $display("differential_drive_odometry_top_tb NOT OK");
        end
        $finish;
    end
endmodule
